FILE: hw/rtl/psh_pkg.sv
// ----------------------------------------------------------------------------
// psh_pkg: shared types and constants of the point-segment Hausdorff block
// Widths, request codes, state encoding and the records that travel between
// the distance front end and the row of divider cells.
// ----------------------------------------------------------------------------
package psh_pkg;

  localparam int COORD_W      = 16;
  localparam int MAX_POINTS   = 1024;
  localparam int MAX_SEGMENTS = 1024;
  localparam int PT_IDX_W     = $clog2(MAX_POINTS);
  localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
  localparam int PT_CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int PT_W         = 2 * COORD_W;
  localparam int SEG_W        = 4 * COORD_W;

  localparam int DIFF_W     = COORD_W + 1;   // coordinate difference
  localparam int PROD_W     = 2 * DIFF_W;    // product of two differences
  localparam int SQ_W       = 2 * DIFF_W;    // squared distance, unsigned
  localparam int DOT_W      = PROD_W + 1;    // dot and cross products
  localparam int HALF_W     = SQ_W / 2;      // half of a split operand
  localparam int NUM_W      = 2 * SQ_W;      // squared cross product
  localparam int DIV_STEPS  = SQ_W;          // one quotient bit per cell
  localparam int DIST_W     = SQ_W / 2;      // square root width
  localparam int ROOT_STEPS = DIST_W;
  localparam int REM_W      = DIST_W + 1;
  localparam int STEP_W     = $clog2(ROOT_STEPS + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [1:0] REQ_POINT   = 2'd0;
  localparam logic [1:0] REQ_SEGMENT = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD,
    ST_DRAIN,
    ST_SQRT_GO,
    ST_SQRT,
    ST_DONE
  } state_t;

  // Tag of one point/segment pair as it walks down the pipeline.
  typedef struct packed {
    logic valid;
    logic first;   // opens a minimum group
    logic last;    // closes a minimum group
    logic pass;    // 0 forward, 1 backward
    logic fin;     // last pair of the whole walk
  } meta_t;

  // Working record of one restoring-division step.
  typedef struct packed {
    logic [SQ_W-1:0] r;
    logic [SQ_W-1:0] d;
    logic [SQ_W-1:0] nlow;
    logic [SQ_W-1:0] q;
  } div_lane_t;

endpackage

FILE: hw/rtl/psh_ram.sv
// ----------------------------------------------------------------------------
// psh_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/psh_front.sv
// ----------------------------------------------------------------------------
// psh_front: point-to-segment distance front end
// Six stages from one pair to a dividend and divisor: a clamped endpoint
// distance passes as itself over one, an interior one as cross^2 over length^2.
// ----------------------------------------------------------------------------
module psh_front (
  input  logic                 clk,
  input  logic                 rst,
  input  psh_pkg::meta_t       in_meta,
  input  psh_pkg::coord_t      p_x,
  input  psh_pkg::coord_t      p_y,
  input  psh_pkg::coord_t      a_x,
  input  psh_pkg::coord_t      a_y,
  input  psh_pkg::coord_t      b_x,
  input  psh_pkg::coord_t      b_y,
  output psh_pkg::meta_t       out_meta,
  output psh_pkg::div_lane_t   out_lane
);

  psh_pkg::meta_t m1, m2, m3, m4, m5;

  logic signed [psh_pkg::DIFF_W-1:0] dx, dy, px, py, qx, qy;
  logic signed [psh_pkg::PROD_W-1:0] dxdx, dydy, pxdx, pydy, pxdy, pydx;
  logic signed [psh_pkg::PROD_W-1:0] pxpx, pypy, qxqx, qyqy;
  logic [psh_pkg::SQ_W-1:0]          len2, da, db;
  logic signed [psh_pkg::DOT_W-1:0]  dot, xprod;
  logic                              inner4, inner5;
  logic [psh_pkg::SQ_W-1:0]          direct4, direct5, c4, d4, d5;
  logic [2*psh_pkg::HALF_W-1:0]      c0c0, c0c1, c1c1;
  logic                              near_a, far_b;
  logic signed [psh_pkg::DOT_W-1:0]  cross_abs;
  logic [psh_pkg::NUM_W-1:0]         num_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1       <= '0;
      m2       <= '0;
      m3       <= '0;
      m4       <= '0;
      m5       <= '0;
      out_meta <= '0;
    end else begin
      m1       <= in_meta;
      m2       <= m1;
      m3       <= m2;
      m4       <= m3;
      m5       <= m4;
      out_meta <= m5;
    end
  end

  // differences
  always_ff @(posedge clk) begin
    dx <= psh_pkg::DIFF_W'(b_x) - psh_pkg::DIFF_W'(a_x);
    dy <= psh_pkg::DIFF_W'(b_y) - psh_pkg::DIFF_W'(a_y);
    px <= psh_pkg::DIFF_W'(p_x) - psh_pkg::DIFF_W'(a_x);
    py <= psh_pkg::DIFF_W'(p_y) - psh_pkg::DIFF_W'(a_y);
    qx <= psh_pkg::DIFF_W'(p_x) - psh_pkg::DIFF_W'(b_x);
    qy <= psh_pkg::DIFF_W'(p_y) - psh_pkg::DIFF_W'(b_y);
  end

  // products
  always_ff @(posedge clk) begin
    dxdx <= dx * dx;
    dydy <= dy * dy;
    pxdx <= px * dx;
    pydy <= py * dy;
    pxdy <= px * dy;
    pydx <= py * dx;
    pxpx <= px * px;
    pypy <= py * py;
    qxqx <= qx * qx;
    qyqy <= qy * qy;
  end

  // sums
  always_ff @(posedge clk) begin
    len2  <= $unsigned(dxdx) + $unsigned(dydy);
    da    <= $unsigned(pxpx) + $unsigned(pypy);
    db    <= $unsigned(qxqx) + $unsigned(qyqy);
    dot   <= psh_pkg::DOT_W'(pxdx) + psh_pkg::DOT_W'(pydy);
    xprod <= psh_pkg::DOT_W'(pxdy) - psh_pkg::DOT_W'(pydx);
  end

  // clamp to an endpoint or keep the interior projection
  always_comb begin
    near_a    = (len2 == '0) || dot[psh_pkg::DOT_W-1] || (dot == '0);
    far_b     = (dot >= $signed({1'b0, len2}));
    cross_abs = xprod[psh_pkg::DOT_W-1] ? -xprod : xprod;
  end

  always_ff @(posedge clk) begin
    inner4  <= !near_a && !far_b;
    direct4 <= near_a ? da : db;
    c4      <= cross_abs[psh_pkg::SQ_W-1:0];
    d4      <= len2;
  end

  // split square of the cross product
  always_ff @(posedge clk) begin
    c0c0    <= c4[psh_pkg::HALF_W-1:0] * c4[psh_pkg::HALF_W-1:0];
    c0c1    <= c4[psh_pkg::HALF_W-1:0] * c4[psh_pkg::SQ_W-1:psh_pkg::HALF_W];
    c1c1    <= c4[psh_pkg::SQ_W-1:psh_pkg::HALF_W] * c4[psh_pkg::SQ_W-1:psh_pkg::HALF_W];
    inner5  <= inner4;
    direct5 <= direct4;
    d5      <= d4;
  end

  always_comb begin
    num_sum = (psh_pkg::NUM_W'(c1c1) << psh_pkg::SQ_W)
            + (psh_pkg::NUM_W'(c0c1) << (psh_pkg::HALF_W + 1))
            + psh_pkg::NUM_W'(c0c0);
  end

  always_ff @(posedge clk) begin
    if (inner5) begin
      out_lane.r    <= num_sum[psh_pkg::NUM_W-1:psh_pkg::SQ_W];
      out_lane.nlow <= num_sum[psh_pkg::SQ_W-1:0];
      out_lane.d    <= d5;
    end else begin
      out_lane.r    <= '0;
      out_lane.nlow <= direct5;
      out_lane.d    <= psh_pkg::SQ_W'(1);
    end
    out_lane.q <= '0;
  end

endmodule

FILE: hw/rtl/psh_div_cell.sv
// ----------------------------------------------------------------------------
// psh_div_cell: one restoring-division cell
// Shift in one dividend bit, subtract the divisor when it fits, hand the
// partial remainder and quotient to the next cell.
// ----------------------------------------------------------------------------
module psh_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  psh_pkg::meta_t      in_meta,
  input  psh_pkg::div_lane_t  in_lane,
  output psh_pkg::meta_t      out_meta,
  output psh_pkg::div_lane_t  out_lane
);

  logic [psh_pkg::SQ_W:0] rs, diff;
  logic                   ge;

  always_comb begin
    rs   = {in_lane.r, in_lane.nlow[psh_pkg::SQ_W-1]};
    diff = rs - {1'b0, in_lane.d};
    ge   = (rs >= {1'b0, in_lane.d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_meta <= '0;
    end else begin
      out_meta <= in_meta;
    end
  end

  always_ff @(posedge clk) begin
    out_lane.r    <= ge ? diff[psh_pkg::SQ_W-1:0] : rs[psh_pkg::SQ_W-1:0];
    out_lane.d    <= in_lane.d;
    out_lane.nlow <= {in_lane.nlow[psh_pkg::SQ_W-2:0], 1'b0};
    out_lane.q    <= {in_lane.q[psh_pkg::SQ_W-2:0], ge};
  end

endmodule

FILE: hw/rtl/psh_isqrt.sv
// ----------------------------------------------------------------------------
// psh_isqrt: iterative floor square root
// Two radicand bits per cycle, one root bit per cycle.
// ----------------------------------------------------------------------------
module psh_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [psh_pkg::SQ_W-1:0]    value,
  output logic                        done,
  output logic [psh_pkg::DIST_W-1:0]  root
);

  logic [psh_pkg::STEP_W-1:0] cnt;
  logic [psh_pkg::SQ_W-1:0]   v;
  logic [psh_pkg::REM_W-1:0]  rem;
  logic [psh_pkg::REM_W+1:0]  rs, trial, diff;
  logic                       ge;

  always_comb begin
    rs    = {rem, v[psh_pkg::SQ_W-1:psh_pkg::SQ_W-2]};
    trial = {1'b0, root, 2'b01};
    diff  = rs - trial;
    ge    = (rs >= trial);
    done  = (cnt == psh_pkg::STEP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= psh_pkg::STEP_W'(psh_pkg::ROOT_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - psh_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= value;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      v    <= {v[psh_pkg::SQ_W-3:0], 2'b00};
      rem  <= ge ? diff[psh_pkg::REM_W-1:0] : rs[psh_pkg::REM_W-1:0];
      root <= {root[psh_pkg::DIST_W-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/point_segment_hausdorff_distance.sv
// ----------------------------------------------------------------------------
// point_segment_hausdorff_distance: symmetric point/segment Hausdorff distance
// Stores target points and model segments, then on a compute request walks
// every pair through a distance front end and a row of division cells and
// reports floor square roots of the directed maxima of minima.
// ----------------------------------------------------------------------------
//
//  channel   ports                              transfer when
//  -------   --------------------------------   ----------------------------
//  request   req_type x_a y_a x_b y_b           start high and busy low
//  flow      busy                               (level, high during compute)
//  result    distance forward_distance          valid high, one cycle only
//            backward_distance empty_set
//            load_overflow
//
//  Point and segment loads may follow back to back.
//  A compute with T points and S segments keeps busy high while the pair
//  walk issues one pair per cycle (T*S forward pairs, 2*S*T backward
//  pairs), then the 41-stage pipe drains, then a start state launches the
//  square root, which runs to its last step, and a done state emits.
//  With an empty set the compute goes straight to the done state.
//  Reset is synchronous on rst and empties both stores.
//  The receiver cannot stall: a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module point_segment_hausdorff_distance (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          req_type,
  input  logic signed [psh_pkg::COORD_W-1:0]  x_a,
  input  logic signed [psh_pkg::COORD_W-1:0]  y_a,
  input  logic signed [psh_pkg::COORD_W-1:0]  x_b,
  input  logic signed [psh_pkg::COORD_W-1:0]  y_b,
  output logic                                valid,
  output logic [psh_pkg::DIST_W-1:0]          distance,
  output logic [psh_pkg::DIST_W-1:0]          forward_distance,
  output logic [psh_pkg::DIST_W-1:0]          backward_distance,
  output logic                                empty_set,
  output logic                                load_overflow
);

  psh_pkg::state_t state, state_next;

  logic [psh_pkg::PT_CNT_W-1:0]  t_cnt;
  logic [psh_pkg::SEG_CNT_W-1:0] s_cnt;
  logic                          ovf, empty_q;
  logic [psh_pkg::PT_IDX_W-1:0]  i_idx;
  logic [psh_pkg::SEG_IDX_W-1:0] j_idx;
  logic                          e_sel, ep0;

  logic accept, load_pt, load_seg, do_compute, pt_full, seg_full, empty_now;
  logic pt_we, seg_we, t_last, s_last;
  logic issue, sq_go, emit;

  psh_pkg::meta_t     meta_issue, meta0;
  psh_pkg::meta_t     cmeta [psh_pkg::DIV_STEPS+1];
  psh_pkg::div_lane_t clane [psh_pkg::DIV_STEPS+1];

  logic [psh_pkg::PT_W-1:0]  pt_rdata;
  logic [psh_pkg::SEG_W-1:0] seg_rdata;
  psh_pkg::coord_t           sa_x, sa_y, sb_x, sb_y, fa_x, fa_y, fb_x, fb_y;

  psh_pkg::meta_t           mo;
  logic [psh_pkg::SQ_W-1:0] dq, best, best_next, fwd_acc, bwd_acc;
  logic [psh_pkg::DIST_W-1:0] root_f, root_b;
  logic                       done_f, done_b;

  // ---------------------------------------------------------------- requests
  always_comb begin
    accept     = start && !busy;
    pt_full    = (t_cnt == psh_pkg::PT_CNT_W'(psh_pkg::MAX_POINTS));
    seg_full   = (s_cnt == psh_pkg::SEG_CNT_W'(psh_pkg::MAX_SEGMENTS));
    load_pt    = accept && (req_type == psh_pkg::REQ_POINT);
    load_seg   = accept && (req_type == psh_pkg::REQ_SEGMENT);
    do_compute = accept && (req_type == psh_pkg::REQ_COMPUTE);
    pt_we      = load_pt && !pt_full;
    seg_we     = load_seg && !seg_full;
    empty_now  = (t_cnt == '0) || (s_cnt == '0);
    t_last     = (psh_pkg::PT_CNT_W'(i_idx) == t_cnt - psh_pkg::PT_CNT_W'(1));
    s_last     = (psh_pkg::SEG_CNT_W'(j_idx) == s_cnt - psh_pkg::SEG_CNT_W'(1));
  end

  // ---------------------------------------------------------------- stores
  psh_ram #(
    .WIDTH (psh_pkg::PT_W),
    .DEPTH (psh_pkg::MAX_POINTS)
  ) u_target_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (t_cnt[psh_pkg::PT_IDX_W-1:0]),
    .wdata ({x_a, y_a}),
    .raddr (i_idx),
    .rdata (pt_rdata)
  );

  psh_ram #(
    .WIDTH (psh_pkg::SEG_W),
    .DEPTH (psh_pkg::MAX_SEGMENTS)
  ) u_segment_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (s_cnt[psh_pkg::SEG_IDX_W-1:0]),
    .wdata ({x_a, y_a, x_b, y_b}),
    .raddr (j_idx),
    .rdata (seg_rdata)
  );

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      psh_pkg::ST_IDLE: begin
        if (do_compute) begin
          state_next = empty_now ? psh_pkg::ST_DONE : psh_pkg::ST_FWD;
        end
      end
      psh_pkg::ST_FWD: begin
        if (t_last && s_last) begin
          state_next = psh_pkg::ST_BWD;
        end
      end
      psh_pkg::ST_BWD: begin
        if (t_last && e_sel && s_last) begin
          state_next = psh_pkg::ST_DRAIN;
        end
      end
      psh_pkg::ST_DRAIN: begin
        if (mo.valid && mo.fin) begin
          state_next = psh_pkg::ST_SQRT_GO;
        end
      end
      psh_pkg::ST_SQRT_GO: state_next = psh_pkg::ST_SQRT;
      psh_pkg::ST_SQRT: begin
        if (done_f) begin
          state_next = psh_pkg::ST_DONE;
        end
      end
      psh_pkg::ST_DONE: state_next = psh_pkg::ST_IDLE;
      default: state_next = psh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    sq_go = 1'b0;
    emit  = 1'b0;
    unique case (state)
      psh_pkg::ST_IDLE:    busy  = 1'b0;
      psh_pkg::ST_FWD:     issue = 1'b1;
      psh_pkg::ST_BWD:     issue = 1'b1;
      psh_pkg::ST_DRAIN:   busy  = 1'b1;
      psh_pkg::ST_SQRT_GO: sq_go = 1'b1;
      psh_pkg::ST_SQRT:    busy  = 1'b1;
      psh_pkg::ST_DONE:    emit  = 1'b1;
      default:             busy  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill counts, the overflow flag and the empty flag; drop both stores as the result is emitted.
  always_ff @(posedge clk) begin
    if (rst) begin
      t_cnt   <= '0;
      s_cnt   <= '0;
      ovf     <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      if (pt_we) begin
        t_cnt <= t_cnt + psh_pkg::PT_CNT_W'(1);
      end
      if (seg_we) begin
        s_cnt <= s_cnt + psh_pkg::SEG_CNT_W'(1);
      end
      if ((load_pt && pt_full) || (load_seg && seg_full)) begin
        ovf <= 1'b1;
      end
      if (do_compute) begin
        empty_q <= empty_now;
      end
      if (emit) begin
        t_cnt <= '0;
        s_cnt <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // Pair walk. Forward: point outer, segment inner. Backward: segment outer,
  // endpoint, then point inner.
  always_ff @(posedge clk) begin
    if (rst) begin
      i_idx <= '0;
      j_idx <= '0;
      e_sel <= 1'b0;
    end else if (do_compute) begin
      i_idx <= '0;
      j_idx <= '0;
      e_sel <= 1'b0;
    end else if (state == psh_pkg::ST_FWD) begin
      if (s_last) begin
        j_idx <= '0;
        i_idx <= t_last ? '0 : i_idx + psh_pkg::PT_IDX_W'(1);
      end else begin
        j_idx <= j_idx + psh_pkg::SEG_IDX_W'(1);
      end
    end else if (state == psh_pkg::ST_BWD) begin
      if (t_last) begin
        i_idx <= '0;
        e_sel <= !e_sel;
        if (e_sel) begin
          j_idx <= j_idx + psh_pkg::SEG_IDX_W'(1);
        end
      end else begin
        i_idx <= i_idx + psh_pkg::PT_IDX_W'(1);
      end
    end
  end

  always_comb begin
    meta_issue.valid = issue;
    meta_issue.pass  = (state == psh_pkg::ST_BWD);
    meta_issue.first = meta_issue.pass ? (i_idx == '0) : (j_idx == '0);
    meta_issue.last  = meta_issue.pass ? t_last : s_last;
    meta_issue.fin   = meta_issue.pass && t_last && e_sel && s_last;
  end

  // Align the tag with the registered RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      meta0 <= '0;
    end else begin
      meta0 <= meta_issue;
    end
  end

  always_ff @(posedge clk) begin
    ep0 <= e_sel;
  end

  // ---------------------------------------------------------------- datapath
  // In the backward walk an endpoint stands in as a zero-length segment.
  always_comb begin
    {sa_x, sa_y, sb_x, sb_y} = seg_rdata;
    if (meta0.pass) begin
      fa_x = ep0 ? sb_x : sa_x;
      fa_y = ep0 ? sb_y : sa_y;
      fb_x = fa_x;
      fb_y = fa_y;
    end else begin
      fa_x = sa_x;
      fa_y = sa_y;
      fb_x = sb_x;
      fb_y = sb_y;
    end
  end

  psh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_meta  (meta0),
    .p_x      (pt_rdata[psh_pkg::PT_W-1:psh_pkg::COORD_W]),
    .p_y      (pt_rdata[psh_pkg::COORD_W-1:0]),
    .a_x      (fa_x),
    .a_y      (fa_y),
    .b_x      (fb_x),
    .b_y      (fb_y),
    .out_meta (cmeta[0]),
    .out_lane (clane[0])
  );

  for (genvar k = 0; k < psh_pkg::DIV_STEPS; k++) begin : g_cell
    psh_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_meta  (cmeta[k]),
      .in_lane  (clane[k]),
      .out_meta (cmeta[k+1]),
      .out_lane (clane[k+1])
    );
  end

  // ---------------------------------------------------------------- reduce
  // Minimum within a group, maximum across groups, one per walk.
  always_comb begin
    mo = cmeta[psh_pkg::DIV_STEPS];
    dq = clane[psh_pkg::DIV_STEPS].q;
    best_next = (mo.first || dq < best) ? dq : best;
  end

  always_ff @(posedge clk) begin
    if (do_compute) begin
      fwd_acc <= '0;
      bwd_acc <= '0;
    end else if (mo.valid) begin
      best <= best_next;
      if (mo.last && !mo.pass && best_next > fwd_acc) begin
        fwd_acc <= best_next;
      end
      if (mo.last && mo.pass && best_next > bwd_acc) begin
        bwd_acc <= best_next;
      end
    end
  end

  psh_isqrt u_root_fwd (
    .clk   (clk),
    .rst   (rst),
    .start (sq_go),
    .value (fwd_acc),
    .done  (done_f),
    .root  (root_f)
  );

  psh_isqrt u_root_bwd (
    .clk   (clk),
    .rst   (rst),
    .start (sq_go),
    .value (bwd_acc),
    .done  (done_b),
    .root  (root_b)
  );

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (empty_q) begin
        distance          <= psh_pkg::DIST_MAX;
        forward_distance  <= psh_pkg::DIST_MAX;
        backward_distance <= psh_pkg::DIST_MAX;
      end else begin
        distance          <= (root_f > root_b) ? root_f : root_b;
        forward_distance  <= root_f;
        backward_distance <= root_b;
      end
      empty_set     <= empty_q;
      load_overflow <= ovf;
    end
  end

  // ---------------------------------------------------------------- checks
  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(state == psh_pkg::ST_DONE))
    else $error("result strobe without a finished compute");

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(pt_we || seg_we))
    else $error("store written during compute");

  a_roots_agree: assert property (@(posedge clk) disable iff (rst)
    (state == psh_pkg::ST_SQRT) |-> (done_f == done_b))
    else $error("square root units out of step");

  a_stores_cleared: assert property (@(posedge clk) disable iff (rst)
    valid |-> (t_cnt == '0 && s_cnt == '0 && !ovf))
    else $error("stores not emptied after the result");

  a_distance_is_max: assert property (@(posedge clk) disable iff (rst)
    valid |-> (distance >= forward_distance && distance >= backward_distance))
    else $error("distance below a directed part");

endmodule
